// ===== sv/assert_macros.svh =====
// assertion macros used by the arbiter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property checked on every rising clock edge outside reset
`define ASSERT_AR(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
// property checked on every rising clock edge, also during reset
`define ASSERT_NR(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");
`else
`define ASSERT_AR(label, clk, rst_n, prop)
`define ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== sv/pti_pkg.sv =====
// types and codes of the pen and touch arbiter
package pti_pkg;
	localparam int IdW = 5;
	localparam int DevW = 3;
	localparam int PhaseW = 2;
	localparam int ActW = 3;
	localparam int OwnW = 3;

	typedef enum logic [OwnW-1:0] {
		OWN_NONE    = 3'd0,
		OWN_PEN     = 3'd1,
		OWN_PENDING = 3'd2,
		OWN_XFORM   = 3'd3,
		OWN_BLOCK   = 3'd4
	} owner_t;

	typedef enum logic [ActW-1:0] {
		ACT_CONSUME  = 3'd0,
		ACT_PEN_DOWN = 3'd1,
		ACT_PEN_MOVE = 3'd2,
		ACT_PEN_UP   = 3'd3,
		ACT_ABORT    = 3'd4,
		ACT_BEGIN    = 3'd5,
		ACT_UPDATE   = 3'd6,
		ACT_END      = 3'd7
	} action_t;

	localparam logic REQ_EVENT = 1'b0;
	localparam logic REQ_CANCEL_ALL = 1'b1;

	localparam logic [DevW-1:0] DEV_PEN = 3'd0;
	localparam logic [DevW-1:0] DEV_ERASER = 3'd1;
	localparam logic [DevW-1:0] DEV_FINGER = 3'd2;

	localparam logic [PhaseW-1:0] PH_DOWN = 2'd0;
	localparam logic [PhaseW-1:0] PH_MOVE = 2'd1;
	localparam logic [PhaseW-1:0] PH_UP = 2'd2;
	localparam logic [PhaseW-1:0] PH_CANCEL = 2'd3;
endpackage

// ===== sv/pti_req_if.sv =====
// request channel: pointer event or cancel-all
interface pti_req_if;
	import pti_pkg::*;
	logic valid;
	logic ready;
	logic req_type;
	logic [DevW-1:0] device;
	logic [PhaseW-1:0] phase;
	logic [IdW-1:0] ptr_id;

	modport source(output valid, req_type, device, phase, ptr_id, input ready);
	modport sink(input valid, req_type, device, phase, ptr_id, output ready);
endinterface

// ===== sv/pti_res_if.sv =====
// result channel: routing action and owner after the event
interface pti_res_if;
	import pti_pkg::*;
	logic valid;
	logic ready;
	logic [ActW-1:0] action;
	logic [OwnW-1:0] owner_now;

	modport source(output valid, action, owner_now, input ready);
	modport sink(input valid, action, owner_now, output ready);
endinterface

// ===== sv/pen_touch_input_arbiter.sv =====
// Pen and touch pointer-event arbiter.
// req channel: one transaction per pointer event (device, phase, pointer id)
// or a cancel-all request (req_type set, other fields ignored).
// res channel: one transaction per request with the routing action and the
// owner after the event, in request order.
// The owner, the owning pen id and the touch/ignored-pen masks are updated in
// the cycle a request is accepted; the result sits in one output register.
// The result is valid in the cycle after the request is accepted.
// Throughput: one request per cycle; req.ready is high whenever the output
// register is empty or being taken in the same cycle.
// When the receiver stalls, the result holds and req.ready stays low, so new
// requests wait until res.ready returns.
// Reset: owner none, no pen held, both masks clear, no result pending.
// Pointer ids not below ID_COUNT, mouse and unknown devices are consumed with
// no change of state.
`include "assert_macros.svh"

module pen_touch_input_arbiter #(
	parameter int ID_COUNT = 32
) (
	input logic clk,
	input logic arst_n,
	pti_req_if.sink req,
	pti_res_if.source res
);
	import pti_pkg::*;

	localparam int MaskW = ID_COUNT;
	localparam int CmpW = ($clog2(ID_COUNT + 1) > IdW) ? $clog2(ID_COUNT + 1) : IdW;

	owner_t owner_q, owner_d;
	logic pen_valid_q, pen_valid_d;
	logic [IdW-1:0] pen_id_q, pen_id_d;
	logic [MaskW-1:0] touch_q, touch_d;
	logic [MaskW-1:0] ignored_q, ignored_d;

	logic res_valid_s1;
	action_t action_s1;
	owner_t owner_s1;

	action_t act;
	logic accept;
	logic in_range;
	logic pen_hit;
	logic two_down;
	logic [MaskW-1:0] id_bit;
	logic [MaskW-1:0] touch_set;
	logic [MaskW-1:0] touch_clr;
	logic [MaskW-1:0] set_low;
	logic [MaskW-1:0] set_rest;

	assign req.ready = !res_valid_s1 || res.ready;
	assign accept = req.valid && req.ready;

	assign in_range = CmpW'(req.ptr_id) < CmpW'(ID_COUNT);
	assign id_bit = MaskW'(1) << req.ptr_id;
	assign touch_set = touch_q | id_bit;
	assign touch_clr = touch_q & ~id_bit;
	assign pen_hit = (owner_q == OWN_PEN) && pen_valid_q && (pen_id_q == req.ptr_id);

	// exactly two bits: clearing the lowest set bit leaves a single bit
	assign set_low = touch_set & (touch_set - MaskW'(1));
	assign set_rest = set_low & (set_low - MaskW'(1));
	assign two_down = (set_low != '0) && (set_rest == '0);

	always_comb begin
		owner_d = owner_q;
		pen_valid_d = pen_valid_q;
		pen_id_d = pen_id_q;
		touch_d = touch_q;
		ignored_d = ignored_q;
		act = ACT_CONSUME;
		if (req.req_type == REQ_CANCEL_ALL) begin
			if (owner_q == OWN_PEN && pen_valid_q)
				act = ACT_ABORT;
			else if (owner_q == OWN_XFORM)
				act = ACT_END;
			owner_d = OWN_NONE;
			pen_valid_d = 1'b0;
			pen_id_d = '0;
			touch_d = '0;
			ignored_d = '0;
		end else if (in_range && (req.device == DEV_PEN || req.device == DEV_ERASER)) begin
			unique case (req.phase)
				PH_DOWN: begin
					if (owner_q == OWN_NONE) begin
						owner_d = OWN_PEN;
						pen_valid_d = 1'b1;
						pen_id_d = req.ptr_id;
						act = ACT_PEN_DOWN;
					end else begin
						ignored_d = ignored_q | id_bit;
					end
				end
				PH_MOVE: begin
					if (pen_hit)
						act = ACT_PEN_MOVE;
				end
				PH_UP: begin
					priority if ((ignored_q & id_bit) != '0) begin
						ignored_d = ignored_q & ~id_bit;
					end else if (pen_hit) begin
						owner_d = (touch_q == '0) ? OWN_NONE : OWN_BLOCK;
						pen_valid_d = 1'b0;
						pen_id_d = '0;
						act = ACT_PEN_UP;
					end else begin
						act = ACT_CONSUME;
					end
				end
				PH_CANCEL: begin
					ignored_d = ignored_q & ~id_bit;
					if (pen_hit) begin
						owner_d = (touch_q == '0) ? OWN_NONE : OWN_BLOCK;
						pen_valid_d = 1'b0;
						pen_id_d = '0;
						act = ACT_ABORT;
					end
				end
				default: act = ACT_CONSUME;
			endcase
		end else if (in_range && req.device == DEV_FINGER) begin
			unique case (req.phase)
				PH_DOWN: begin
					touch_d = touch_set;
					if (owner_q == OWN_NONE) begin
						owner_d = OWN_PENDING;
					end else if (owner_q == OWN_PENDING && two_down) begin
						owner_d = OWN_XFORM;
						act = ACT_BEGIN;
					end
				end
				PH_MOVE: begin
					if (owner_q == OWN_XFORM && (touch_q & id_bit) != '0)
						act = ACT_UPDATE;
				end
				PH_UP, PH_CANCEL: begin
					touch_d = touch_clr;
					priority if (owner_q == OWN_XFORM) begin
						owner_d = (touch_clr == '0) ? OWN_NONE : OWN_BLOCK;
						act = ACT_END;
					end else if ((owner_q == OWN_PENDING || owner_q == OWN_BLOCK)
							&& touch_clr == '0) begin
						owner_d = OWN_NONE;
					end else begin
						act = ACT_CONSUME;
					end
				end
				default: act = ACT_CONSUME;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= OWN_NONE;
			pen_valid_q <= 1'b0;
			pen_id_q <= '0;
			touch_q <= '0;
			ignored_q <= '0;
		end else if (accept) begin
			owner_q <= owner_d;
			pen_valid_q <= pen_valid_d;
			pen_id_q <= pen_id_d;
			touch_q <= touch_d;
			ignored_q <= ignored_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (req.ready) begin
			res_valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= act;
			owner_s1 <= owner_d;
		end
	end

	assign res.valid = res_valid_s1;
	assign res.action = action_s1;
	assign res.owner_now = owner_s1;

	// a held pen id exists exactly while a pen owns the stream
	`ASSERT_AR(a_pen_held, clk, arst_n, pen_valid_q == (owner_q == OWN_PEN))
	// no owner means no touch is down
	`ASSERT_AR(a_none_no_touch, clk, arst_n, (owner_q == OWN_NONE) |-> (touch_q == '0))
	// a transform always has at least two touches down
	`ASSERT_AR(a_xform_two, clk, arst_n, (owner_q == OWN_XFORM) |-> ($countones(touch_q) >= 2))
	// every accepted transaction leaves a result pending
	`ASSERT_AR(a_result_follows, clk, arst_n, accept |=> res_valid_s1)
endmodule
